// ----- rtl/core/tbpw_pkg.sv -----
// ----------------------------------------------------------------------------
// tbpw_pkg
// shared types, widths and constants of the tile border point warp block
// ----------------------------------------------------------------------------
package tbpw_pkg;

  localparam int unsigned DATA_W  = 32;  // Q16.16 words
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned RAND_W  = 16;
  localparam int unsigned INT_W   = 17;  // rounded integer part and offsets
  localparam int unsigned MAG_W   = 16;  // offset magnitude, up to one half
  localparam int unsigned CL_W    = 47;  // c * left, up to 2^46
  localparam int unsigned CR_W    = 48;  // c + c * right
  localparam int unsigned NUM_W   = 62;  // rounded ratio numerator
  localparam int unsigned DEN_W   = 16;
  localparam int unsigned QUO_W   = 47;  // divider stages, one quotient bit each
  localparam int unsigned V_W     = 49;  // displacement before weighting
  localparam int unsigned SPLIT_W = 24;  // weight multiply split
  localparam int unsigned PART_W  = SPLIT_W + DATA_W;
  localparam int unsigned WSUM_W  = 2 * SPLIT_W + DATA_W;
  localparam int unsigned WMAG_W  = WSUM_W - FRAC_W;

  localparam int unsigned OFIFO_DEPTH = 64;
  localparam int unsigned OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int unsigned CNT_W       = OFIFO_AW + 1;

  typedef enum logic [1:0] {
    REG_WEIGHT         = 2'd0,
    REG_CENTER_SCALE   = 2'd1,
    REG_LEFT_SHIFT     = 2'd2,
    REG_RIGHT_FRACTION = 2'd3
  } reg_idx_t;

  localparam logic [DATA_W-1:0] WEIGHT_RST = 32'h0001_0000;
  localparam logic [DATA_W-1:0] CENTER_RST = 32'h0000_8000;
  localparam logic [DATA_W-1:0] LEFT_RST   = 32'h0000_8000;
  localparam logic [DATA_W-1:0] RIGHT_RST  = 32'h0000_8000;

  localparam logic [FRAC_W-1:0] HALF_LSB = 16'h8000;

  typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] center_scale;
    logic signed [DATA_W-1:0] left_shift;
    logic signed [DATA_W-1:0] right_fraction;
  } cfg_t;

  // classified point, front to back
  typedef struct packed {
    logic [RAND_W-1:0] rand_frac;
    logic [INT_W-1:0]  rx;
    logic [INT_W-1:0]  ry;
    logic [INT_W-1:0]  ox;
    logic [INT_W-1:0]  oy;
    logic [MAG_W-1:0]  ax;
    logic [MAG_W-1:0]  ay;
    logic              xdom;
  } item_t;

  // data that rides alongside the divider
  typedef struct packed {
    logic [V_W-1:0]  bx;
    logic [V_W-1:0]  by;
    logic [CL_W-1:0] cl;
    logic            push;
    logic            xdom;
    logic            sx;
    logic            sy;
    logic            zero;
  } side_t;

  // magnitude with zero replaced by one lsb
  function automatic logic [DATA_W-1:0] abs_nz(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] a;
    a = v[DATA_W-1] ? (~v + 32'd1) : v;
    if (a == '0) a = 32'd1;
    return a;
  endfunction

endpackage

// ----- rtl/core/tbpw_front.sv -----
// ----------------------------------------------------------------------------
// tbpw_front
// accepts points, rounds them ties to even and queues the classified word
// ----------------------------------------------------------------------------
module tbpw_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [31:0]                x_in,
  input  logic [31:0]                y_in,
  input  logic [15:0]                rand_frac,
  input  logic                       q_take,
  output logic                       q_valid,
  output tbpw_pkg::item_t            q_item
);

  localparam int unsigned SPLIT_BITS = 2 * tbpw_pkg::INT_W + tbpw_pkg::MAG_W;

  // {rounded integer, offset, offset magnitude}
  function automatic logic [SPLIT_BITS-1:0] round_split(input logic [31:0] v);
    logic                         up;
    logic [tbpw_pkg::INT_W-1:0]   rx;
    logic [tbpw_pkg::INT_W-1:0]   ox;
    logic [tbpw_pkg::INT_W-1:0]   neg;
    up  = (v[15:0] > tbpw_pkg::HALF_LSB) || ((v[15:0] == tbpw_pkg::HALF_LSB) && v[16]);
    rx  = {v[31], v[31:16]} + {16'd0, up};
    ox  = {1'b0, v[15:0]} - {up, 16'd0};
    neg = ~ox + 17'd1;
    return {rx, ox, ox[16] ? neg[15:0] : ox[15:0]};
  endfunction

  tbpw_pkg::item_t        entry [2];
  logic                   wr_idx;
  logic                   rd_idx;
  logic [1:0]             cnt;
  logic [SPLIT_BITS-1:0]  sx;
  logic [SPLIT_BITS-1:0]  sy;
  tbpw_pkg::item_t        cls;
  logic                   accept;

  always_comb begin
    sx            = round_split(x_in);
    sy            = round_split(y_in);
    cls.rand_frac = rand_frac;
    cls.rx        = sx[SPLIT_BITS-1 -: tbpw_pkg::INT_W];
    cls.ox        = sx[tbpw_pkg::MAG_W +: tbpw_pkg::INT_W];
    cls.ax        = sx[tbpw_pkg::MAG_W-1:0];
    cls.ry        = sy[SPLIT_BITS-1 -: tbpw_pkg::INT_W];
    cls.oy        = sy[tbpw_pkg::MAG_W +: tbpw_pkg::INT_W];
    cls.ay        = sy[tbpw_pkg::MAG_W-1:0];
    cls.xdom      = cls.ax >= cls.ay;
  end

  assign full    = (cnt == 2'd2);
  assign accept  = push && !full;
  assign q_valid = (cnt != 2'd0);
  assign q_item  = entry[rd_idx];

  always_ff @(posedge clk) begin
    if (accept) begin
      entry[wr_idx] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (accept) wr_idx <= !wr_idx;
      if (q_take) rd_idx <= !rd_idx;
      cnt <= cnt + {1'b0, accept} - {1'b0, q_take};
    end
  end

endmodule

// ----- rtl/core/tbpw_div.sv -----
// ----------------------------------------------------------------------------
// tbpw_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tbpw_div (
  input  logic                           clk,
  input  logic [tbpw_pkg::NUM_W-1:0]     num,
  input  logic [tbpw_pkg::DEN_W-1:0]     den,
  output logic [tbpw_pkg::QUO_W-1:0]     quo
);

  localparam int unsigned QW = tbpw_pkg::QUO_W;
  localparam int unsigned DW = tbpw_pkg::DEN_W;

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [QW-1:0] rest_r [QW-1];
  logic [DW-1:0] den_r  [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_c;
    logic [QW-1:0] rest_c;
    logic [QW-1:0] quo_c;
    logic [DW-1:0] den_c;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      // top bits are known to be below the divisor
      assign rem_c  = {1'b0, num[tbpw_pkg::NUM_W-1:QW]};
      assign rest_c = num[QW-1:0];
      assign quo_c  = '0;
      assign den_c  = den;
    end else begin : g_next
      assign rem_c  = rem_r[k-1];
      assign rest_c = rest_r[k-1];
      assign quo_c  = quo_r[k-1];
      assign den_c  = den_r[k-1];
    end

    assign trial = {rem_c, rest_c[QW-1]};
    assign diff  = trial - {1'b0, den_c};
    assign ge    = trial >= {1'b0, den_c};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r[k] <= {quo_c[QW-2:0], ge};
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rest_r[k] <= {rest_c[QW-2:0], 1'b0};
        den_r[k]  <= den_c;
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// ----- rtl/core/tbpw_back.sv -----
// ----------------------------------------------------------------------------
// tbpw_back
// scaling, border push, ratio division, weighting and result queue
// ----------------------------------------------------------------------------
module tbpw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tbpw_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  input  tbpw_pkg::item_t      q_item,
  output logic                 q_take,
  input  logic                 pop,
  output logic                 empty,
  output logic [31:0]          dx,
  output logic [31:0]          dy
);

  localparam int unsigned VW = tbpw_pkg::V_W;
  localparam int unsigned QW = tbpw_pkg::QUO_W;
  localparam int unsigned DW = tbpw_pkg::DATA_W;

  function automatic logic [DW-1:0] sat(input logic [tbpw_pkg::WMAG_W-1:0] m,
                                        input logic neg);
    logic [DW-1:0] r;
    if (m >= 64'h8000_0000) begin
      r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = neg ? (~m[DW-1:0] + 32'd1) : m[DW-1:0];
    end
    return r;
  endfunction

  // stage 1: raw products
  logic                      s1_v;
  tbpw_pkg::item_t           s1_it;
  logic [47:0]               s1_mcx;
  logic [47:0]               s1_mcy;
  logic [63:0]               s1_clp;
  logic [63:0]               s1_crp;
  logic [DW-1:0]             s1_c;
  logic [DW-1:0]             c_mag;
  logic [DW-1:0]             l_mag;
  logic [DW-1:0]             r_mag;

  // stage 2: rounded scale terms, push decision
  logic                      s2_v;
  tbpw_pkg::side_t           s2_sd;
  logic [15:0]               s2_major;
  logic [15:0]               s2_minor;
  tbpw_pkg::side_t           s2_nx;
  logic [47:0]               pcx_r;
  logic [47:0]               pcy_r;
  logic [VW-1:0]             rxs;
  logic [VW-1:0]             rys;
  logic [VW-1:0]             pcx;
  logic [VW-1:0]             pcy;
  logic [63:0]               clr;
  logic [63:0]               crr;
  logic [tbpw_pkg::CR_W-1:0] cr;

  // stage 3 and 4: ratio numerator
  logic                      s3_v;
  tbpw_pkg::side_t           s3_sd;
  logic [15:0]               s3_major;
  logic [62:0]               s3_prod;
  logic                      s4_v;
  tbpw_pkg::side_t           s4_sd;
  logic [tbpw_pkg::NUM_W-1:0] s4_num;
  logic [15:0]               s4_den;

  // alongside the divider
  logic [QW-1:0]             line_v;
  tbpw_pkg::side_t           line [QW];
  logic [QW-1:0]             quo;

  // displacement, weighting
  logic                      sa_v;
  logic [VW-1:0]             sa_vx;
  logic [VW-1:0]             sa_vy;
  tbpw_pkg::side_t           sd;
  logic [VW-1:0]             clv;
  logic [VW-1:0]             rtv;
  logic [VW-1:0]             add_x;
  logic [VW-1:0]             add_y;
  logic                      ma_v;
  logic [tbpw_pkg::PART_W-1:0] ma_xlo;
  logic [tbpw_pkg::PART_W-1:0] ma_xhi;
  logic [tbpw_pkg::PART_W-1:0] ma_ylo;
  logic [tbpw_pkg::PART_W-1:0] ma_yhi;
  logic                      ma_xn;
  logic                      ma_yn;
  logic [VW-1:0]             vxm;
  logic [VW-1:0]             vym;
  logic [DW-1:0]             wm;
  logic                      mb_v;
  logic [tbpw_pkg::WMAG_W-1:0] mb_xm;
  logic [tbpw_pkg::WMAG_W-1:0] mb_ym;
  logic                      mb_xn;
  logic                      mb_yn;
  logic [tbpw_pkg::WSUM_W-1:0] xsum;
  logic [tbpw_pkg::WSUM_W-1:0] ysum;

  // result queue
  logic [2*DW-1:0]               ofifo [tbpw_pkg::OFIFO_DEPTH];
  logic [tbpw_pkg::OFIFO_AW-1:0] wr_ptr;
  logic [tbpw_pkg::OFIFO_AW-1:0] rd_ptr;
  logic [tbpw_pkg::CNT_W-1:0]    mem_cnt;
  logic [tbpw_pkg::CNT_W-1:0]    credit;
  logic                          rd_en;
  logic                          out_v;
  logic [2*DW-1:0]               out_word;
  logic                          pop_acc;

  // words in flight plus waiting never exceed the queue
  assign q_take  = q_valid && !credit[tbpw_pkg::CNT_W-1];
  assign pop_acc = pop && out_v;
  assign rd_en   = (mem_cnt != '0) && (!out_v || pop);

  assign c_mag = tbpw_pkg::abs_nz(cfg.center_scale);
  assign l_mag = tbpw_pkg::abs_nz(cfg.left_shift);
  assign r_mag = tbpw_pkg::abs_nz(cfg.right_fraction);

  always_ff @(posedge clk) begin
    s1_it  <= q_item;
    s1_mcx <= 48'(q_item.ax) * 48'(c_mag);
    s1_mcy <= 48'(q_item.ay) * 48'(c_mag);
    s1_clp <= 64'(c_mag) * 64'(l_mag);
    s1_crp <= 64'(c_mag) * 64'(r_mag);
    s1_c   <= c_mag;
  end

  always_comb begin
    pcx_r = s1_mcx + 48'(tbpw_pkg::HALF_LSB);
    pcy_r = s1_mcy + 48'(tbpw_pkg::HALF_LSB);
    pcx   = {17'd0, pcx_r[47:16]};
    pcy   = {17'd0, pcy_r[47:16]};
    rxs   = {{16{s1_it.rx[16]}}, s1_it.rx, 16'h0};
    rys   = {{16{s1_it.ry[16]}}, s1_it.ry, 16'h0};
    clr   = s1_clp + 64'(tbpw_pkg::HALF_LSB);
    crr   = s1_crp + 64'(tbpw_pkg::HALF_LSB);
    cr    = {16'd0, s1_c} + {1'b0, crr[62:16]};
    s2_nx.bx   = s1_it.ox[16] ? rxs - pcx : rxs + pcx;
    s2_nx.by   = s1_it.oy[16] ? rys - pcy : rys + pcy;
    s2_nx.cl   = clr[62:16];
    s2_nx.push = {32'd0, s1_it.rand_frac} < cr;
    s2_nx.xdom = s1_it.xdom;
    s2_nx.sx   = s1_it.ox[16];
    s2_nx.sy   = s1_it.oy[16];
    s2_nx.zero = s1_it.xdom ? (s1_it.ax == '0) : (s1_it.ay == '0);
  end

  always_ff @(posedge clk) begin
    s2_sd    <= s2_nx;
    s2_major <= s1_it.xdom ? s1_it.ax : s1_it.ay;
    s2_minor <= s1_it.xdom ? s1_it.ay : s1_it.ax;
    s3_sd    <= s2_sd;
    s3_major <= s2_major;
    s3_prod  <= 63'(s2_sd.cl) * 63'(s2_minor);
    s4_sd    <= s3_sd;
    // round half up before dividing
    s4_num   <= s3_prod[tbpw_pkg::NUM_W-1:0] + {47'd0, s3_major[15:1]};
    s4_den   <= s3_major;
  end

  tbpw_div u_div (
    .clk (clk),
    .num (s4_num),
    .den (s4_den),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    line[0] <= s4_sd;
    for (int k = 1; k < QW; k++) begin
      line[k] <= line[k-1];
    end
  end

  always_comb begin
    sd  = line[QW-1];
    clv = {2'b0, sd.cl};
    rtv = sd.zero ? '0 : {2'b0, quo};
    add_x = '0;
    add_y = '0;
    if (sd.push) begin
      if (sd.xdom) begin
        add_x = sd.sx ? -clv : clv;
        add_y = sd.sy ? -rtv : rtv;
      end else begin
        add_y = sd.sy ? -clv : clv;
        add_x = sd.sx ? -rtv : rtv;
      end
    end
  end

  always_comb begin
    vxm = sa_vx[VW-1] ? -sa_vx : sa_vx;
    vym = sa_vy[VW-1] ? -sa_vy : sa_vy;
    wm  = cfg.weight[DW-1] ? (~cfg.weight + 32'd1) : cfg.weight;
    xsum = {ma_xhi, 24'd0} + {24'd0, ma_xlo} + 80'(tbpw_pkg::HALF_LSB);
    ysum = {ma_yhi, 24'd0} + {24'd0, ma_ylo} + 80'(tbpw_pkg::HALF_LSB);
  end

  always_ff @(posedge clk) begin
    sa_vx  <= sd.bx + add_x;
    sa_vy  <= sd.by + add_y;
    ma_xlo <= tbpw_pkg::PART_W'(vxm[23:0]) * tbpw_pkg::PART_W'(wm);
    ma_xhi <= tbpw_pkg::PART_W'(vxm[47:24]) * tbpw_pkg::PART_W'(wm);
    ma_ylo <= tbpw_pkg::PART_W'(vym[23:0]) * tbpw_pkg::PART_W'(wm);
    ma_yhi <= tbpw_pkg::PART_W'(vym[47:24]) * tbpw_pkg::PART_W'(wm);
    ma_xn  <= sa_vx[VW-1] ^ cfg.weight[DW-1];
    ma_yn  <= sa_vy[VW-1] ^ cfg.weight[DW-1];
    mb_xm  <= xsum[tbpw_pkg::WSUM_W-1:tbpw_pkg::FRAC_W];
    mb_ym  <= ysum[tbpw_pkg::WSUM_W-1:tbpw_pkg::FRAC_W];
    mb_xn  <= ma_xn;
    mb_yn  <= ma_yn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      s3_v   <= 1'b0;
      s4_v   <= 1'b0;
      line_v <= '0;
      sa_v   <= 1'b0;
      ma_v   <= 1'b0;
      mb_v   <= 1'b0;
    end else begin
      s1_v   <= q_take;
      s2_v   <= s1_v;
      s3_v   <= s2_v;
      s4_v   <= s3_v;
      line_v <= {line_v[QW-2:0], s4_v};
      sa_v   <= line_v[QW-1];
      ma_v   <= sa_v;
      mb_v   <= ma_v;
    end
  end

  always_ff @(posedge clk) begin
    if (mb_v) begin
      ofifo[wr_ptr] <= {sat(mb_xm, mb_xn), sat(mb_ym, mb_yn)};
    end
    if (rd_en) begin
      out_word <= ofifo[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      mem_cnt <= '0;
      credit  <= '0;
      out_v   <= 1'b0;
    end else begin
      if (mb_v)  wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      mem_cnt <= mem_cnt + tbpw_pkg::CNT_W'(mb_v) - tbpw_pkg::CNT_W'(rd_en);
      credit  <= credit + tbpw_pkg::CNT_W'(q_take) - tbpw_pkg::CNT_W'(pop_acc);
      if (rd_en) begin
        out_v <= 1'b1;
      end else if (pop_acc) begin
        out_v <= 1'b0;
      end
    end
  end

  assign empty = !out_v;
  assign dx    = out_word[2*DW-1:DW];
  assign dy    = out_word[DW-1:0];

endmodule

// ----- rtl/core/tile_border_point_warp.sv -----
// ----------------------------------------------------------------------------
// tile_border_point_warp
// border tiling point warp: rounded, scaled and pushed displacement, weighted
// ----------------------------------------------------------------------------
// input side is a queue: a word (x_in, y_in, rand_frac) is taken on a clock
// edge with push high and full low. result side is a queue too: while empty is
// low, dx and dy hold the oldest result word, taken on an edge with pop high.
// one result word comes out for every input word, in order.
// configuration goes through cfg_valid / cfg_ready / cfg_index / cfg_data;
// cfg_ready is always high, writes belong in idle periods.
// a word passes the input queue, stages s1 to s4, the divider and sa, ma, mb.
// throughput: one word per cycle while under 64 words are outstanding. the
// ratio divider is a 47-stage pipeline, one quotient bit per stage, and every
// multiplier output is registered. a 64-word result queue takes all words in
// flight; when the receiver stalls, issue stops once 64 words are outstanding,
// the 2-word input queue fills and full goes high.
// reset (rst, synchronous) empties both queues, drops words in flight and
// loads weight 1.0, center_scale, left_shift and right_fraction 0.5.
// ----------------------------------------------------------------------------
module tile_border_point_warp (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] x_in,
  input  logic [31:0] y_in,
  input  logic [15:0] rand_frac,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] dx,
  output logic [31:0] dy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  tbpw_pkg::cfg_t  cfg;
  tbpw_pkg::item_t q_item;
  logic            q_valid;
  logic            q_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight         <= tbpw_pkg::WEIGHT_RST;
      cfg.center_scale   <= tbpw_pkg::CENTER_RST;
      cfg.left_shift     <= tbpw_pkg::LEFT_RST;
      cfg.right_fraction <= tbpw_pkg::RIGHT_RST;
    end else if (cfg_valid) begin
      case (tbpw_pkg::reg_idx_t'(cfg_index))
        tbpw_pkg::REG_WEIGHT:         cfg.weight         <= cfg_data;
        tbpw_pkg::REG_CENTER_SCALE:   cfg.center_scale   <= cfg_data;
        tbpw_pkg::REG_LEFT_SHIFT:     cfg.left_shift     <= cfg_data;
        tbpw_pkg::REG_RIGHT_FRACTION: cfg.right_fraction <= cfg_data;
        default: ;
      endcase
    end
  end

  tbpw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .x_in      (x_in),
    .y_in      (y_in),
    .rand_frac (rand_frac),
    .q_take    (q_take),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  tbpw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take),
    .pop     (pop),
    .empty   (empty),
    .dx      (dx),
    .dy      (dy)
  );

endmodule
